FILE: hw/rtl/sitda_pkg.sv
`timescale 1ns / 1ps

package sitda_pkg;

  // Default width of the signed input value.
  localparam int VALUE_BITS_DEF = 32;

  // Width of one ASCII character.
  localparam int CHAR_W = 8;

  localparam logic [CHAR_W-1:0] ASCII_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] ASCII_MINUS = 8'h2D;

  // Number of decimal digits that is enough for any magnitude of an
  // n-bit two's complement value (1233/4096 approximates log10(2) from just
  // below, which is close enough for every width up to 64 bits).
  function automatic int dec_digits(input int n);
    return ((n * 1233) >> 12) + 1;
  endfunction

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;        // capture a new request and start the conversion
    logic step;        // one shift-and-add-3 step
    logic skip;        // drop one leading zero digit
    logic emit_sign;   // place the minus sign in the output register
    logic emit_digit;  // place the top digit in the output register
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic conv_last;   // the current step consumes the last magnitude bit
    logic top_zero;    // the top BCD digit is zero
    logic rem_one;     // only one digit is left
    logic neg;         // the value is negative
    logic slot_free;   // the output register can take a character
  } sts_t;

endpackage

FILE: hw/rtl/sitda_if.sv
`timescale 1ns / 1ps

interface sitda_in_if #(
  parameter int VALUE_BITS = sitda_pkg::VALUE_BITS_DEF
);
  logic                         valid;
  logic                         ready;
  logic signed [VALUE_BITS-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface sitda_out_if;
  logic                          valid;
  logic                          ready;
  logic [sitda_pkg::CHAR_W-1:0]  text_char;
  logic                          last_char;

  modport source (output valid, output text_char, output last_char, input ready);
  modport sink   (input valid, input text_char, input last_char, output ready);
endinterface

FILE: hw/rtl/signed_int_to_decimal_ascii.sv
`timescale 1ns / 1ps

// Prints a signed two's complement integer as decimal ASCII text, one
// character per output request, most significant character first. A negative
// value is preceded by a minus sign, zero prints as the single character '0',
// leading zeros never appear, and last_char marks the final character of each
// number. The most negative value prints in full because the magnitude is an
// unsigned VALUE_BITS-bit quantity. The block works on one number at a time:
// after a request is taken, a shift-and-add-3 binary to BCD converter works
// through the magnitude one bit per step into D BCD digits (D = 10 at 32
// bits), each suppressed leading zero is dropped in a step of its own, and
// then one character leaves per cycle while the output side is ready. The
// last character of a number may still wait in the output register while the
// next request is accepted.
module signed_int_to_decimal_ascii #(
  parameter int VALUE_BITS = sitda_pkg::VALUE_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  sitda_in_if.sink      in_if,
  sitda_out_if.source   out_if
);
  import sitda_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // The controller sequences load, conversion, zero suppression and output.
  sitda_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_if.valid),
    .in_ready (in_if.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // The datapath holds the magnitude, the BCD digits and the output register.
  sitda_dp #(
    .VALUE_BITS (VALUE_BITS)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_value      (in_if.value),
    .cmd           (cmd),
    .sts           (sts),
    .out_ready     (out_if.ready),
    .out_valid     (out_if.valid),
    .out_text_char (out_if.text_char),
    .out_last_char (out_if.last_char)
  );

`ifndef ASSERT_OFF
  // The controller never issues more than one command in a cycle.
  a_one_cmd : assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(cmd))
    else $error("more than one datapath command at once");

  // A character is only written when the output register can take it.
  a_emit_free : assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit_sign || cmd.emit_digit) |-> sts.slot_free)
    else $error("character written over a pending output");

  // Once a request is accepted, no other request is taken until its final character is written.
  a_busy : assert property (@(posedge clk) disable iff (!rst_n)
    (in_if.valid && in_if.ready) |=> !in_if.ready)
    else $error("input accepted while a number is in progress");

  // After the final character is written the block is ready again.
  a_done : assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit_digit && sts.rem_one) |=> (in_if.ready && out_if.valid && out_if.last_char))
    else $error("final character did not end the number");
`endif

endmodule

FILE: hw/rtl/sitda_ctrl.sv
`timescale 1ns / 1ps

module sitda_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  sitda_pkg::sts_t sts,
  output sitda_pkg::cmd_t cmd
);
  import sitda_pkg::*;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_CONV  = 3'd1;
  localparam logic [2:0] ST_SKIP  = 3'd2;
  localparam logic [2:0] ST_SIGN  = 3'd3;
  localparam logic [2:0] ST_DIGIT = 3'd4;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    in_ready  = (state_r == ST_IDLE);
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_CONV;
        end
      end
      ST_CONV: begin
        cmd.step = 1'b1;
        if (sts.conv_last) begin
          state_nxt = ST_SKIP;
        end
      end
      ST_SKIP: begin
        if (sts.top_zero && !sts.rem_one) begin
          cmd.skip = 1'b1;
        end else begin
          state_nxt = sts.neg ? ST_SIGN : ST_DIGIT;
        end
      end
      ST_SIGN: begin
        if (sts.slot_free) begin
          cmd.emit_sign = 1'b1;
          state_nxt     = ST_DIGIT;
        end
      end
      ST_DIGIT: begin
        if (sts.slot_free) begin
          cmd.emit_digit = 1'b1;
          if (sts.rem_one) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

FILE: hw/rtl/sitda_dp.sv
`timescale 1ns / 1ps

module sitda_dp #(
  parameter int VALUE_BITS = sitda_pkg::VALUE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic signed [VALUE_BITS-1:0]  in_value,
  input  sitda_pkg::cmd_t               cmd,
  output sitda_pkg::sts_t               sts,
  input  logic                          out_ready,
  output logic                          out_valid,
  output logic [sitda_pkg::CHAR_W-1:0]  out_text_char,
  output logic                          out_last_char
);
  import sitda_pkg::*;

  localparam int NDIG = dec_digits(VALUE_BITS);
  localparam int BW   = NDIG * 4;
  localparam int BITW = $clog2(VALUE_BITS + 1);
  localparam int RW   = $clog2(NDIG + 1);

  logic [VALUE_BITS-1:0] mag_r,  mag_nxt;
  logic [BW-1:0]         bcd_r,  bcd_nxt;
  logic [BITW-1:0]       bits_r, bits_nxt;
  logic [RW-1:0]         rem_r,  rem_nxt;
  logic                  neg_r,  neg_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [CHAR_W-1:0]     out_char_r,  out_char_nxt;
  logic                  out_last_r,  out_last_nxt;
  logic [BW-1:0]         bcd_adj;
  logic [3:0]            top_digit;
  logic                  slot_free;

  assign top_digit = bcd_r[BW-1 -: 4];
  assign slot_free = !out_valid_r || out_ready;

  // Each BCD digit of five or more gets three added before the shift.
  always_comb begin
    for (int i = 0; i < NDIG; i++) begin
      bcd_adj[i*4 +: 4] = (bcd_r[i*4 +: 4] >= 4'd5) ? bcd_r[i*4 +: 4] + 4'd3
                                                    : bcd_r[i*4 +: 4];
    end
  end

  always_comb begin
    mag_nxt       = mag_r;
    bcd_nxt       = bcd_r;
    bits_nxt      = bits_r;
    rem_nxt       = rem_r;
    neg_nxt       = neg_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;
    if (cmd.load) begin
      neg_nxt  = in_value[VALUE_BITS-1];
      mag_nxt  = in_value[VALUE_BITS-1] ? (~in_value + VALUE_BITS'(1)) : in_value;
      bcd_nxt  = '0;
      bits_nxt = BITW'(VALUE_BITS);
      rem_nxt  = RW'(NDIG);
    end
    if (cmd.step) begin
      bcd_nxt  = {bcd_adj[BW-2:0], mag_r[VALUE_BITS-1]};
      mag_nxt  = {mag_r[VALUE_BITS-2:0], 1'b0};
      bits_nxt = bits_r - BITW'(1);
    end
    if (cmd.skip) begin
      bcd_nxt = {bcd_r[BW-5:0], 4'd0};
      rem_nxt = rem_r - RW'(1);
    end
    if (cmd.emit_sign) begin
      out_valid_nxt = 1'b1;
      out_char_nxt  = ASCII_MINUS;
      out_last_nxt  = 1'b0;
    end
    if (cmd.emit_digit) begin
      out_valid_nxt = 1'b1;
      out_char_nxt  = ASCII_ZERO + {4'd0, top_digit};
      out_last_nxt  = (rem_r == RW'(1));
      bcd_nxt       = {bcd_r[BW-5:0], 4'd0};
      rem_nxt       = rem_r - RW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mag_r      <= mag_nxt;
    bcd_r      <= bcd_nxt;
    bits_r     <= bits_nxt;
    rem_r      <= rem_nxt;
    neg_r      <= neg_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
  end

  assign sts.conv_last = (bits_r == BITW'(1));
  assign sts.top_zero  = (top_digit == 4'd0);
  assign sts.rem_one   = (rem_r == RW'(1));
  assign sts.neg       = neg_r;
  assign sts.slot_free = slot_free;

  assign out_valid     = out_valid_r;
  assign out_text_char = out_char_r;
  assign out_last_char = out_last_r;

endmodule
